// ===== design/vbrco_pkg.sv =====
// ----------------------------------------------------------------------------
// vbrco_pkg
// Types and constants shared by the rotated 1bpp byte color overlay block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vbrco_pkg;

  localparam int unsigned MAX_FRAME_SIDE    = 1024;

  localparam int unsigned TOP_LIMIT         = 60;
  localparam int unsigned LEFT_TEXT_LIMIT   = 16;
  localparam int unsigned RIGHT_TEXT_MARGIN = 122;
  localparam int unsigned TEXT_ROW_LIMIT    = 15;
  localparam int unsigned BAND_START_MARGIN = 64;
  localparam int unsigned BAND_END_MARGIN   = 33;

  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned BROW_W    = 7;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned IDX_W     = 20;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_PLAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BAND   = 3'd5;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd224;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd256;
  localparam logic [COLOR_W-1:0] RST_COLOR_OFF    = 16'hF000;
  localparam logic [COLOR_W-1:0] RST_COLOR_TOP    = 16'hF0F0;
  localparam logic [COLOR_W-1:0] RST_COLOR_PLAIN  = 16'hFFFF;
  localparam logic [COLOR_W-1:0] RST_COLOR_BAND   = 16'hFF00;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [COLOR_W-1:0] color_off;
    logic [COLOR_W-1:0] color_top;
    logic [COLOR_W-1:0] color_plain;
    logic [COLOR_W-1:0] color_band;
  } cfg_t;

  typedef struct packed {
    logic               oor;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] set_color;
  } zone_t;

endpackage

`default_nettype wire

// ===== design/vbrco_zone.sv =====
// ----------------------------------------------------------------------------
// vbrco_zone
// Range check, rotated row of bit 0 and zone color for one row group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbrco_zone (
  input  var vbrco_pkg::cfg_t                 cfg_i,
  input  wire logic [vbrco_pkg::COL_W-1:0]    column_i,
  input  wire logic [vbrco_pkg::BROW_W-1:0]   byte_row_i,
  output vbrco_pkg::zone_t                    zone_o
);
  import vbrco_pkg::*;

  logic [DIM_W-1:0] base;
  logic [DIM_W-1:0] col_x;
  logic [DIM_W-1:0] diff;
  logic             in_top;
  logic             in_text;
  logic             right_text;
  logic             band_lo;
  logic             band_hi;

  assign base  = {1'b0, byte_row_i, 3'b000};
  assign col_x = {1'b0, column_i};
  assign diff  = cfg_i.frame_height - base - 11'd1;

  always_comb begin
    in_top     = base <= DIM_W'(TOP_LIMIT);
    right_text = (cfg_i.frame_width < DIM_W'(RIGHT_TEXT_MARGIN)) ||
                 (col_x >= cfg_i.frame_width - DIM_W'(RIGHT_TEXT_MARGIN));
    in_text    = (base <= DIM_W'(TEXT_ROW_LIMIT)) &&
                 ((col_x <= DIM_W'(LEFT_TEXT_LIMIT)) || right_text);
    band_lo    = (cfg_i.frame_height < DIM_W'(BAND_START_MARGIN)) ||
                 (base >= cfg_i.frame_height - DIM_W'(BAND_START_MARGIN));
    band_hi    = (cfg_i.frame_height >= DIM_W'(BAND_END_MARGIN)) &&
                 (base <= cfg_i.frame_height - DIM_W'(BAND_END_MARGIN));

    if (in_top) begin
      zone_o.set_color = in_text ? cfg_i.color_plain : cfg_i.color_top;
    end else if (band_lo && band_hi) begin
      zone_o.set_color = cfg_i.color_band;
    end else begin
      zone_o.set_color = cfg_i.color_plain;
    end

    zone_o.oor = (col_x >= cfg_i.frame_width) ||
                 ({1'b0, base} + 12'd8 > {1'b0, cfg_i.frame_height}) ||
                 (32'(cfg_i.frame_width) > MAX_FRAME_SIDE) ||
                 (32'(cfg_i.frame_height) > MAX_FRAME_SIDE);
    zone_o.row = zone_o.oor ? '0 : diff[ROW_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/vbrco_lane.sv =====
// ----------------------------------------------------------------------------
// vbrco_lane
// One pixel lane: picks the zone color or the clear color from one bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbrco_lane (
  input  wire logic                          bit_i,
  input  wire logic [vbrco_pkg::COLOR_W-1:0] set_color_i,
  input  wire logic [vbrco_pkg::COLOR_W-1:0] off_color_i,
  output logic      [vbrco_pkg::COLOR_W-1:0] pixel_o
);
  import vbrco_pkg::*;

  always_comb begin
    pixel_o = bit_i ? set_color_i : off_color_i;
  end

endmodule

`default_nettype wire

// ===== design/vbrco_index.sv =====
// ----------------------------------------------------------------------------
// vbrco_index
// Frame index of bit 0: row times frame width plus column, 20-bit wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbrco_index (
  input  wire logic [vbrco_pkg::ROW_W-1:0] row_i,
  input  wire logic [vbrco_pkg::DIM_W-1:0] width_i,
  input  wire logic [vbrco_pkg::COL_W-1:0] column_i,
  input  wire logic                        oor_i,
  output logic      [vbrco_pkg::IDX_W-1:0] index_o
);
  import vbrco_pkg::*;

  logic [ROW_W+DIM_W-1:0] prod;
  logic [ROW_W+DIM_W-1:0] sum;

  always_comb begin
    prod    = row_i * width_i;
    sum     = prod + (ROW_W+DIM_W)'(column_i);
    index_o = oor_i ? '0 : sum[IDX_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/vram_byte_rotate_color_overlay.sv =====
// Pipeline: stage 1 registers the zone decode with the eight pixel lanes and
// stage 2 the index multiply before the result reaches the master side.
// Throughput: one transaction per cycle while m_tready_i does not stall it.
// Reset: asynchronous, active low; clears pipeline valids and loads the
// default frame size and colors into the configuration registers.
// ----------------------------------------------------------------------------
// vram_byte_rotate_color_overlay
// Rotates one 1bpp video memory byte into frame coordinates and colors its
// eight pixels by screen zone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vram_byte_rotate_color_overlay (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  // column[9:0], byte_row[16:10], vram_byte[24:17], zero[31:25]
  input  wire logic [31:0]  s_tdata_i,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  // bit0_row[9:0], out_column[19:10], frame_index[39:20], pixel0..pixel7
  // [167:40] at 16 bits each
  output logic [167:0]      m_tdata_o,
  // out_of_range[0]
  output logic [0:0]        m_tuser_o
);
  import vbrco_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_wdata_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_wdata_i[DIM_W-1:0];
        REG_COLOR_OFF:    cfg_d.color_off    = cfg_wdata_i;
        REG_COLOR_TOP:    cfg_d.color_top    = cfg_wdata_i;
        REG_COLOR_PLAIN:  cfg_d.color_plain  = cfg_wdata_i;
        REG_COLOR_BAND:   cfg_d.color_band   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.color_off    <= RST_COLOR_OFF;
      cfg_q.color_top    <= RST_COLOR_TOP;
      cfg_q.color_plain  <= RST_COLOR_PLAIN;
      cfg_q.color_band   <= RST_COLOR_BAND;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage 1: zone decode and pixel lanes
  logic [COL_W-1:0]  in_col;
  logic [BROW_W-1:0] in_brow;
  logic [7:0]        in_byte;
  zone_t             zone;
  logic [NUM_LANES-1:0][COLOR_W-1:0] lane_pix;

  assign in_col  = s_tdata_i[9:0];
  assign in_brow = s_tdata_i[16:10];
  assign in_byte = s_tdata_i[24:17];

  vbrco_zone u_zone (
    .cfg_i      (cfg_q),
    .column_i   (in_col),
    .byte_row_i (in_brow),
    .zone_o     (zone)
  );

  for (genvar n = 0; n < NUM_LANES; n++) begin : g_lane
    vbrco_lane u_lane (
      .bit_i       (in_byte[n]),
      .set_color_i (zone.set_color),
      .off_color_i (cfg_q.color_off),
      .pixel_o     (lane_pix[n])
    );
  end

  logic                              s1_valid_q;
  logic                              s1_oor_q;
  logic [ROW_W-1:0]                  s1_row_q;
  logic [COL_W-1:0]                  s1_col_q;
  logic [NUM_LANES-1:0][COLOR_W-1:0] s1_pix_q;
  logic                              s1_ready;
  logic                              s2_ready;

  assign s2_ready   = !m_tvalid_o || m_tready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s_tready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_tvalid_i) begin
      s1_oor_q <= zone.oor;
      s1_row_q <= zone.row;
      s1_col_q <= in_col;
      s1_pix_q <= lane_pix;
    end
  end

  // stage 2: frame index and merge into the output word
  logic [IDX_W-1:0] index;
  logic             s2_valid_q;
  logic [167:0]     s2_data_q;
  logic             s2_oor_q;

  vbrco_index u_index (
    .row_i    (s1_row_q),
    .width_i  (cfg_q.frame_width),
    .column_i (s1_col_q),
    .oor_i    (s1_oor_q),
    .index_o  (index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= {s1_pix_q, index, s1_col_q, s1_row_q};
      s2_oor_q  <= s1_oor_q;
    end
  end

  assign m_tvalid_o = s2_valid_q;
  assign m_tdata_o  = s2_data_q;
  assign m_tuser_o  = s2_oor_q;

`ifndef SYNTHESIS
  a_stall_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  a_oor_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> (m_tdata_o[9:0] == '0) && (m_tdata_o[39:20] == '0))
    else $error("out of range result carries coordinates");

  a_ready_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (m_tvalid_o && !m_tready_i && s1_valid_q))
    else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
